[sv/sequential_list_engine_macros.svh]
// Assertion macros shared by the list engine checkers.
`ifndef SEQUENTIAL_LIST_ENGINE_MACROS_SVH
`define SEQUENTIAL_LIST_ENGINE_MACROS_SVH

// Consequent checked in the cycle after the antecedent, outside reset.
`define SLE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

// Consequent checked in the same cycle as the antecedent, outside reset.
`define SLE_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Checked at every edge, reset included.
`define SLE_ASSERT_ALWAYS(label, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

[sv/slist_pkg.sv]
// Types, constants and helper functions of the sequential list engine.
package slist_pkg;

  localparam int CAPACITY   = 256;
  localparam int DATA_WIDTH = 32;
  localparam int ADDR_W     = $clog2(CAPACITY);
  localparam int CNT_W      = $clog2(CAPACITY + 1);
  // wide enough for position, count and CAPACITY itself
  localparam int CMP_W      = (CNT_W > 8) ? CNT_W : 9;

  localparam logic [2:0] OP_READ   = 3'd0;
  localparam logic [2:0] OP_FIND   = 3'd1;
  localparam logic [2:0] OP_INSERT = 3'd2;
  localparam logic [2:0] OP_DELETE = 3'd3;
  localparam logic [2:0] OP_DELALL = 3'd4;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_RANGE    = 2'd1;
  localparam logic [1:0] ST_NOTFOUND = 2'd2;
  localparam logic [1:0] ST_FULL     = 2'd3;

  typedef logic [DATA_WIDTH-1:0] word_t;
  typedef logic [ADDR_W-1:0]     addr_t;
  typedef logic [CNT_W-1:0]      cnt_t;

  typedef struct packed {
    logic [2:0]         op;
    logic [7:0]         position;
    logic signed [31:0] value;
  } in_word_t;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] read_value;
    logic [7:0]         found_position;
    logic [8:0]         list_length;
  } out_word_t;

  typedef struct packed {
    logic start;
    logic finish;
  } ctrl_cmd_t;

  typedef struct packed {
    logic walk_done;
  } dp_stat_t;

  function automatic word_t to_word(logic signed [31:0] v);
    logic signed [63:0] ext;
    ext = 64'(v);
    return ext[DATA_WIDTH-1:0];
  endfunction

  function automatic logic signed [31:0] from_word(word_t w);
    logic signed [DATA_WIDTH-1:0] sw;
    logic signed [63:0]           ext;
    sw  = w;
    ext = 64'(sw);
    return ext[31:0];
  endfunction

endpackage

[sv/slist_ctrl.sv]
// Controller state machine of the sequential list engine.
module slist_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  output logic                  out_valid,
  input  logic                  out_ready,
  input  slist_pkg::dp_stat_t   stat,
  output slist_pkg::ctrl_cmd_t  cmd
);

  typedef enum logic [1:0] {S_IDLE, S_WALK, S_FIN} state_t;

  state_t state_r;
  logic   out_valid_r;
  logic   out_free;

  assign out_free   = !out_valid_r || out_ready;
  assign in_ready   = (state_r == S_IDLE);
  assign cmd.start  = in_valid && in_ready;
  assign cmd.finish = (state_r == S_FIN) && out_free;
  assign out_valid  = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      unique case (state_r)
        S_IDLE: if (cmd.start) state_r <= S_WALK;
        S_WALK: if (stat.walk_done) state_r <= S_FIN;
        S_FIN:  if (out_free) state_r <= S_IDLE;
        default: state_r <= S_IDLE;
      endcase
      if (cmd.finish) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

endmodule

[sv/slist_dp.sv]
// Datapath of the sequential list engine: word store, walk pointer, count, result.
module slist_dp (
  input  logic                  clk,
  input  logic                  rst_n,
  input  slist_pkg::ctrl_cmd_t  cmd,
  input  slist_pkg::in_word_t   in_data,
  output slist_pkg::dp_stat_t   stat,
  output slist_pkg::out_word_t  out_data
);

  slist_pkg::word_t mem [slist_pkg::CAPACITY];

  logic [2:0]          op_r;
  slist_pkg::word_t    val_r;
  slist_pkg::addr_t    ins_addr_r;
  logic [1:0]          st_r;
  slist_pkg::cnt_t     cnt_r, cnt_nxt;
  slist_pkg::cnt_t     len_r;
  slist_pkg::addr_t    rd_addr_r;
  logic                dn_r;
  logic                rd_vld_r;
  slist_pkg::addr_t    rd_tag_r;
  slist_pkg::word_t    rd_data_r;
  slist_pkg::cnt_t     keep_r;
  slist_pkg::addr_t    fpos_r;
  slist_pkg::out_word_t out_r, out_nxt;

  // start-of-operation setup
  logic [slist_pkg::CMP_W-1:0] pos_x, cnt_x, cap_x;
  slist_pkg::addr_t pos_a;
  logic [1:0]       st_s;
  slist_pkg::cnt_t  len_s;
  slist_pkg::addr_t addr_s, ins_s;
  logic             dn_s;

  logic             rd_en, match, keep_hit;
  logic             wr_en;
  slist_pkg::addr_t wr_addr;
  slist_pkg::word_t wr_data;

  always_comb begin
    pos_x  = slist_pkg::CMP_W'(in_data.position);
    cnt_x  = slist_pkg::CMP_W'(cnt_r);
    cap_x  = slist_pkg::CMP_W'(slist_pkg::CAPACITY);
    pos_a  = slist_pkg::ADDR_W'(in_data.position);
    st_s   = slist_pkg::ST_OK;
    len_s  = '0;
    addr_s = '0;
    dn_s   = 1'b0;
    ins_s  = pos_a;
    unique case (in_data.op)
      slist_pkg::OP_READ: begin
        if (pos_x >= cnt_x) begin
          st_s = slist_pkg::ST_RANGE;
        end else begin
          len_s  = slist_pkg::CNT_W'(1);
          addr_s = pos_a;
        end
      end
      slist_pkg::OP_FIND: begin
        st_s  = slist_pkg::ST_NOTFOUND;
        len_s = cnt_r;
      end
      slist_pkg::OP_INSERT: begin
        if (pos_x >= cap_x) begin
          st_s = slist_pkg::ST_RANGE;
        end else if (cnt_x >= cap_x) begin
          st_s = slist_pkg::ST_FULL;
        end else if (pos_x >= cnt_x) begin
          ins_s = slist_pkg::ADDR_W'(cnt_r);
        end else begin
          // shift the tail up, top word first
          len_s  = slist_pkg::CNT_W'(cnt_x - pos_x);
          addr_s = slist_pkg::ADDR_W'(cnt_r - 1'b1);
          dn_s   = 1'b1;
        end
      end
      slist_pkg::OP_DELETE: begin
        if (pos_x >= cnt_x) begin
          st_s = slist_pkg::ST_RANGE;
        end else begin
          len_s  = slist_pkg::CNT_W'(cnt_x - pos_x - 1'b1);
          addr_s = slist_pkg::ADDR_W'(pos_x + 1'b1);
        end
      end
      slist_pkg::OP_DELALL: begin
        len_s = cnt_r;
      end
      default: ;
    endcase
  end

  assign rd_en          = (len_r != '0);
  assign stat.walk_done = (len_r == '0) && !rd_vld_r;
  assign match    = rd_vld_r && (op_r == slist_pkg::OP_FIND) &&
                    (st_r == slist_pkg::ST_NOTFOUND) && (rd_data_r == val_r);
  assign keep_hit = rd_vld_r && (op_r == slist_pkg::OP_DELALL) && (rd_data_r != val_r);

  // one write per cycle: walked word during the walk, inserted word at the end
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = rd_tag_r;
    wr_data = rd_data_r;
    if (cmd.finish) begin
      if (op_r == slist_pkg::OP_INSERT && st_r == slist_pkg::ST_OK) begin
        wr_en   = 1'b1;
        wr_addr = ins_addr_r;
        wr_data = val_r;
      end
    end else if (rd_vld_r) begin
      unique case (op_r)
        slist_pkg::OP_INSERT: begin
          wr_en   = 1'b1;
          wr_addr = slist_pkg::addr_t'(rd_tag_r + 1'b1);
        end
        slist_pkg::OP_DELETE: begin
          wr_en   = 1'b1;
          wr_addr = slist_pkg::addr_t'(rd_tag_r - 1'b1);
        end
        slist_pkg::OP_DELALL: begin
          wr_en   = keep_hit;
          wr_addr = slist_pkg::ADDR_W'(keep_r);
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    cnt_nxt = cnt_r;
    if (st_r == slist_pkg::ST_OK) begin
      unique case (op_r)
        slist_pkg::OP_INSERT: cnt_nxt = cnt_r + 1'b1;
        slist_pkg::OP_DELETE: cnt_nxt = cnt_r - 1'b1;
        slist_pkg::OP_DELALL: cnt_nxt = keep_r;
        default: ;
      endcase
    end
    out_nxt.status = st_r;
    if (st_r != slist_pkg::ST_OK) begin
      out_nxt.read_value = '1;
    end else if (op_r == slist_pkg::OP_READ) begin
      out_nxt.read_value = slist_pkg::from_word(rd_data_r);
    end else begin
      out_nxt.read_value = '0;
    end
    out_nxt.found_position = (op_r == slist_pkg::OP_FIND && st_r == slist_pkg::ST_OK) ?
                             8'(fpos_r) : 8'd0;
    out_nxt.list_length = 9'(cnt_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r    <= '0;
      len_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      rd_vld_r <= rd_en;
      if (cmd.start) begin
        len_r <= len_s;
      end else if (rd_en) begin
        len_r <= len_r - 1'b1;
      end
      if (cmd.finish) cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      op_r       <= in_data.op;
      val_r      <= slist_pkg::to_word(in_data.value);
      ins_addr_r <= ins_s;
      st_r       <= st_s;
      rd_addr_r  <= addr_s;
      dn_r       <= dn_s;
      keep_r     <= '0;
      fpos_r     <= '0;
    end else begin
      if (rd_en) rd_addr_r <= dn_r ? rd_addr_r - 1'b1 : rd_addr_r + 1'b1;
      if (match) begin
        st_r   <= slist_pkg::ST_OK;
        fpos_r <= rd_tag_r;
      end
      if (keep_hit) keep_r <= keep_r + 1'b1;
    end
    if (rd_en) rd_tag_r <= rd_addr_r;
    if (cmd.finish) out_r <= out_nxt;
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (rd_en) rd_data_r <= mem[rd_addr_r];
  end

  assign out_data = out_r;

endmodule

[sv/sequential_list_engine.sv]
// Sequential list engine: packed list of signed words with read, find,
// insert, positional delete and delete-all-equal.
//
// Channels: in_valid/in_ready carry one op word (op, position, value);
// out_valid/out_ready return one result word (status, read_value,
// found_position, list_length) per op word.
// Flow: for an accepted op word the engine walks N stored words through the
// one-write/one-read store, one word per cycle, before its result is loaded;
// the next op word is taken in the cycle after the result is loaded. N is 1
// for read, the count for find and delete-all, count - position for insert,
// count - position - 1 for delete, 0 on error or append.
// One op word is in work at a time; the result register lets the next op
// word be accepted while the last result is still waiting.
// Reset (rst_n low, synchronous) empties the list and drops any pending
// result; the store contents are not cleared.
// Receiver stall: a held result holds the engine in its final cycle until
// out_ready; nothing is lost.
module sequential_list_engine (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  slist_pkg::in_word_t  in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output slist_pkg::out_word_t out_data
);

  slist_pkg::ctrl_cmd_t cmd;
  slist_pkg::dp_stat_t  stat;

  slist_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  slist_dp u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .in_data  (in_data),
    .stat     (stat),
    .out_data (out_data)
  );

endmodule

[sv/slist_chk.sv]
// Port-level checker of the sequential list engine and its bind.
`include "sequential_list_engine_macros.svh"

module slist_chk (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 in_valid,
  input logic                 in_ready,
  input logic                 out_valid,
  input logic                 out_ready,
  input slist_pkg::out_word_t out_data
);

  `SLE_ASSERT_ALWAYS(a_rst_clears_out, !rst_n, !out_valid, "result word valid after reset")
  `SLE_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready, "second word taken while busy")
  `SLE_ASSERT_NEXT(a_no_instant_result, in_valid && in_ready, !$rose(out_valid), "result too early")
  `SLE_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data), "stalled result changed")
  `SLE_ASSERT_SAME(a_err_value, out_valid && out_data.status != slist_pkg::ST_OK, out_data.read_value == -32'sd1, "error result without -1")

endmodule

bind sequential_list_engine slist_chk u_slist_chk (.*);
